// ===== hw/rtl/clr_pkg.sv =====
// Shared constants and types for the clamped line rasterizer.
package clr_pkg;

  localparam int DEF_MAX_SCREEN_DIM = 4096;
  localparam int DEF_COORD_WIDTH    = 16;
  localparam int FIFO_DEPTH         = 4;

  localparam int ADDR_W   = 32;
  localparam int SCREEN_W = 13;
  localparam int PITCH_W  = 16;
  localparam int BPP_W    = 3;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int XSTEP_W  = BPP_W + 1;
  localparam int YSTEP_W  = PITCH_W + 1;
  localparam int DSTEP_W  = YSTEP_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES   = 3'd4;

  localparam logic [BPP_W-1:0] BPP_24 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_32 = 3'd4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [ADDR_W-1:0]   RST_FB_BASE       = 32'd0;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [PITCH_W-1:0]  RST_ROW_PITCH     = 16'd2560;
  localparam logic [BPP_W-1:0]    RST_PIXEL_BYTES   = BPP_32;

  typedef struct packed {
    logic [ADDR_W-1:0]   fb_base;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [PITCH_W-1:0]  row_pitch;
    logic [BPP_W-1:0]    pixel_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/clr_if.sv =====
// Valid/ready channel interfaces for line requests and pixel writes.
interface clr_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_WIDTH-1:0] x_start;
  logic signed [COORD_WIDTH-1:0] y_start;
  logic signed [COORD_WIDTH-1:0] x_end;
  logic signed [COORD_WIDTH-1:0] y_end;
  logic [7:0]                    blue;
  logic [7:0]                    green;
  logic [7:0]                    red;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, blue, green, red,
                  input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, blue, green, red,
                  output ready);
endinterface

interface clr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        write_alpha;
  logic        last_pixel;

  modport source (output valid, write_address, out_blue, out_green, out_red, write_alpha,
                  last_pixel, input ready);
  modport sink   (input valid, write_address, out_blue, out_green, out_red, write_alpha,
                  last_pixel, output ready);
endinterface

// ===== hw/rtl/clr_front.sv =====
// Front end: takes requests, clamps endpoints and builds line setup commands.
module clr_front import clr_pkg::*; #(
  parameter int  MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
  parameter int  COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter type cmd_t          = logic
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  clr_in_if.sink    in_i,
  output logic      push_o,
  output cmd_t      cmd_o,
  input  logic      full_i
);

  localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);
  localparam int PIX_W = $clog2(MAX_SCREEN_DIM);
  localparam int CMP_W = ((COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W) + 1;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [SCREEN_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > 32'(MAX_SCREEN_DIM)) begin
      r = DIM_W'(MAX_SCREEN_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] clamp(input logic signed [COORD_WIDTH-1:0] c,
                                             input logic [DIM_W-1:0] dim);
    logic signed [CMP_W-1:0] cw;
    logic signed [CMP_W-1:0] dw;
    logic [PIX_W-1:0]        r;
    cw = CMP_W'(c);
    dw = $signed(CMP_W'(dim));
    if (cw < 0) begin
      r = '0;
    end else if (cw >= dw) begin
      r = PIX_W'(dim - DIM_W'(1));
    end else begin
      r = PIX_W'(cw);
    end
    return r;
  endfunction

  // Stage 1: registered, clamped request
  logic                s1_q;
  logic                mode_q;
  logic [PIX_W-1:0]    x1_q, y1_q, x2_q, y2_q;
  logic [COLOUR_W-1:0] colour_q;

  logic [DIM_W-1:0] w_dim, h_dim;
  logic             fire_in;

  assign w_dim   = eff_dim(cfg_i.screen_width);
  assign h_dim   = eff_dim(cfg_i.screen_height);
  assign push_o  = s1_q && !full_i;
  assign in_i.ready = !s1_q || !full_i;
  assign fire_in = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (fire_in) begin
      s1_q <= 1'b1;
    end else if (push_o) begin
      s1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      mode_q   <= in_i.mode;
      x1_q     <= clamp(in_i.x_start, w_dim);
      y1_q     <= clamp(in_i.y_start, h_dim);
      x2_q     <= clamp(in_i.x_end, w_dim);
      y2_q     <= clamp(in_i.y_end, h_dim);
      colour_q <= {in_i.red, in_i.green, in_i.blue};
    end
  end

  // Stage 2: deltas, steps and start address
  logic signed [PIX_W:0]          dx, dy;
  logic [PIX_W:0]                 ndx, ndy;
  logic                           x_pos, y_pos, x_major, bpp_ok;
  logic [PIX_W-1:0]               adx, ady, major, minor;
  logic signed [XSTEP_W-1:0]      xstep;
  logic signed [YSTEP_W-1:0]      ystep;
  logic [PIX_W+BPP_W-1:0]         xoff;
  logic [PIX_W+PITCH_W-1:0]       yoff;

  always_comb begin
    dx      = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
    dy      = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
    ndx     = -dx;
    ndy     = -dy;
    x_pos   = !dx[PIX_W] && (dx != '0);
    y_pos   = !dy[PIX_W] && (dy != '0);
    adx     = x_pos ? dx[PIX_W-1:0] : ndx[PIX_W-1:0];
    ady     = y_pos ? dy[PIX_W-1:0] : ndy[PIX_W-1:0];
    x_major = adx > ady;          // equal deltas go to y
    major   = x_major ? adx : ady;
    minor   = x_major ? ady : adx;
    bpp_ok  = (cfg_i.pixel_bytes == BPP_24) || (cfg_i.pixel_bytes == BPP_32);
    xstep   = x_pos ? $signed({1'b0, cfg_i.pixel_bytes}) : -$signed({1'b0, cfg_i.pixel_bytes});
    ystep   = y_pos ? $signed({1'b0, cfg_i.row_pitch}) : -$signed({1'b0, cfg_i.row_pitch});
    xoff    = x1_q * cfg_i.pixel_bytes;
    yoff    = y1_q * cfg_i.row_pitch;

    cmd_o.is_start   = (mode_q == MODE_START);
    cmd_o.active     = bpp_ok && (major != '0);
    cmd_o.address    = cfg_i.fb_base + ADDR_W'(xoff) + ADDR_W'(yoff);
    cmd_o.err        = $signed({2'b0, minor, 1'b0}) - $signed({3'b0, major});
    cmd_o.left       = major;
    cmd_o.maj2       = {major, 1'b0};
    cmd_o.min2       = {minor, 1'b0};
    cmd_o.major_step = x_major ? YSTEP_W'(xstep) : ystep;
    cmd_o.diag_step  = DSTEP_W'(xstep) + DSTEP_W'(ystep);
    cmd_o.alpha      = (cfg_i.pixel_bytes == BPP_32);
    cmd_o.colour     = colour_q;
  end

endmodule

// ===== hw/rtl/clr_fifo.sv =====
// Short command queue between front and back ends.
module clr_fifo import clr_pkg::*; #(
  parameter int  DEPTH = FIFO_DEPTH,
  parameter type cmd_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");

endmodule

// ===== hw/rtl/clr_back.sv =====
// Back end: Bresenham stepper and output register for pixel writes.
module clr_back import clr_pkg::*; #(
  parameter int  MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
  parameter type cmd_t          = logic
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  clr_out_if.source  out_o
);

  localparam int PIX_W = $clog2(MAX_SCREEN_DIM);
  localparam int E_W   = PIX_W + 3;

  logic                      active_q;
  logic [ADDR_W-1:0]         addr_q;
  logic signed [E_W-1:0]     err_q;
  logic [PIX_W-1:0]          left_q;
  logic [PIX_W:0]            maj2_q, min2_q;
  logic signed [YSTEP_W-1:0] mstep_q;
  logic signed [DSTEP_W-1:0] dstep_q;
  logic                      alpha_q;
  logic [COLOUR_W-1:0]       colour_q;

  logic                      out_valid_q;
  logic [ADDR_W-1:0]         out_addr_q;
  logic [COLOUR_W-1:0]       out_colour_q;
  logic                      out_alpha_q, out_last_q;

  logic                      emit, e_ge;
  logic signed [E_W-1:0]     err_sub, err_d;
  logic signed [DSTEP_W-1:0] step;

  assign pop_o = !empty_i && (!out_valid_q || out_o.ready);
  assign emit  = pop_o && !cmd_i.is_start && active_q;
  assign e_ge  = !err_q[E_W-1];

  always_comb begin
    err_sub = e_ge ? $signed(E_W'(maj2_q)) : '0;
    err_d   = err_q - err_sub + $signed(E_W'(min2_q));
    step    = e_ge ? dstep_q : DSTEP_W'(mstep_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && cmd_i.is_start) begin
        active_q <= cmd_i.active;
      end else if (emit && left_q == PIX_W'(1)) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.is_start) begin
      addr_q   <= cmd_i.address;
      err_q    <= cmd_i.err;
      left_q   <= cmd_i.left;
      maj2_q   <= cmd_i.maj2;
      min2_q   <= cmd_i.min2;
      mstep_q  <= cmd_i.major_step;
      dstep_q  <= cmd_i.diag_step;
      alpha_q  <= cmd_i.alpha;
      colour_q <= cmd_i.colour;
    end else if (emit) begin
      addr_q <= addr_q + ADDR_W'(step);
      err_q  <= err_d;
      left_q <= left_q - PIX_W'(1);
    end
    if (emit) begin
      out_addr_q   <= addr_q;
      out_colour_q <= colour_q;
      out_alpha_q  <= alpha_q;
      out_last_q   <= (left_q == PIX_W'(1));
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.write_address = out_addr_q;
  assign out_o.out_blue      = out_colour_q[CHAN_W-1:0];
  assign out_o.out_green     = out_colour_q[2*CHAN_W-1:CHAN_W];
  assign out_o.out_red       = out_colour_q[3*CHAN_W-1:2*CHAN_W];
  assign out_o.write_alpha   = out_alpha_q;
  assign out_o.last_pixel    = out_last_q;

  a_active_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> left_q != '0) else $error("active line with no pixels left");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && left_q == PIX_W'(1)) |=> !active_q) else $error("line still active after last pixel");

  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> err_q < $signed(E_W'(min2_q))) else $error("error term out of range");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && left_q != PIX_W'(1)) |=> active_q && !out_last_q)
    else $error("last flag without line end");

endmodule

// ===== hw/rtl/clamped_line_rasterizer_top.sv =====
// Top level of the clamped line rasterizer: configuration registers and datapath.
//
// Each request on in_i is either a line start (mode 0) or a pixel request (mode 1).
// One request is taken every cycle unless stage 1 waits on a full queue; a pixel request
// on an active line gives one pixel write on out_o. A start clamps both endpoints to the
// screen and forms the start address with x * pixel_bytes and y * row_pitch multiplies
// in the front end; the back end then advances the line with one address add and one
// error-term update per pixel, so pixels stream at one per cycle while commands are
// queued and out_o is ready. A four-entry command queue sits between the two, so the
// input keeps flowing while out_o is stalled until the queue and stage 1 fill. Starts,
// pixel requests without an active line and lines of zero length give no write. Registers
// are written through cfg_we_i and must only change while no requests are in flight.
module clamped_line_rasterizer_top import clr_pkg::*; #(
  parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clr_in_if.sink                in_i,
  clr_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PIX_W = $clog2(MAX_SCREEN_DIM);
  localparam int E_W   = PIX_W + 3;

  typedef struct packed {
    logic                      is_start;
    logic                      active;
    logic [ADDR_W-1:0]         address;
    logic signed [E_W-1:0]     err;
    logic [PIX_W-1:0]          left;
    logic [PIX_W:0]            maj2;
    logic [PIX_W:0]            min2;
    logic signed [YSTEP_W-1:0] major_step;
    logic signed [DSTEP_W-1:0] diag_step;
    logic                      alpha;
    logic [COLOUR_W-1:0]       colour;
  } cmd_t;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_base       <= RST_FB_BASE;
      cfg_q.screen_width  <= RST_SCREEN_WIDTH;
      cfg_q.screen_height <= RST_SCREEN_HEIGHT;
      cfg_q.row_pitch     <= RST_ROW_PITCH;
      cfg_q.pixel_bytes   <= RST_PIXEL_BYTES;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FB_BASE:       cfg_q.fb_base       <= cfg_data_i[ADDR_W-1:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[SCREEN_W-1:0];
        REG_ROW_PITCH:     cfg_q.row_pitch     <= cfg_data_i[PITCH_W-1:0];
        REG_PIXEL_BYTES:   cfg_q.pixel_bytes   <= cfg_data_i[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  clr_front #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM),
    .COORD_WIDTH   (COORD_WIDTH),
    .cmd_t         (cmd_t)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  clr_fifo #(
    .DEPTH(FIFO_DEPTH),
    .cmd_t(cmd_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  clr_back #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM),
    .cmd_t         (cmd_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
